[design/dfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types, phase codes and delimiter helpers for the frame parser.
// ----------------------------------------------------------------------------
package dfp_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned NumW   = 32;

  localparam logic [PhaseW-1:0] PH_START   = 4'd0;
  localparam logic [PhaseW-1:0] PH_TYPE    = 4'd1;
  localparam logic [PhaseW-1:0] PH_KEY     = 4'd2;
  localparam logic [PhaseW-1:0] PH_MODULE  = 4'd3;
  localparam logic [PhaseW-1:0] PH_METHOD  = 4'd4;
  localparam logic [PhaseW-1:0] PH_SENDER  = 4'd5;
  localparam logic [PhaseW-1:0] PH_MSGTYPE = 4'd6;
  localparam logic [PhaseW-1:0] PH_SIZE    = 4'd7;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd8;

  localparam logic [7:0] MARK_HASH = 8'h23;
  localparam logic [7:0] MARK_BANG = 8'h21;
  localparam logic [7:0] MARK_BAR  = 8'h7C;

  typedef struct packed {
    logic [NumW-1:0] value;
    logic            digits_only;
  } acc_t;

  function automatic logic [7:0] close_mark(input logic [PhaseW-1:0] ph);
    logic [7:0] m;
    case (ph)
      PH_TYPE:                                m = MARK_BANG;
      PH_KEY, PH_SENDER:                      m = MARK_HASH;
      PH_MODULE, PH_METHOD, PH_MSGTYPE, PH_SIZE: m = MARK_BAR;
      default:                                m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic is_numeric(input logic [PhaseW-1:0] ph);
    return (ph == PH_TYPE) || (ph == PH_MSGTYPE) || (ph == PH_SIZE);
  endfunction

endpackage
`default_nettype wire

[design/dfp_digit_acc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dfp_digit_acc
// Decimal accumulate step: value*10 + digit, saturating at 32 bits; the first
// non-digit freezes the value.
// ----------------------------------------------------------------------------
module dfp_digit_acc (
  input  dfp_pkg::acc_t acc_in,
  input  logic [7:0]    data_byte,
  output dfp_pkg::acc_t acc_out
);
  import dfp_pkg::*;

  localparam int unsigned ProdW = NumW + 4;

  logic             is_digit;
  logic [3:0]       digit;
  logic [ProdW-1:0] prod;

  assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
  assign digit    = data_byte[3:0];
  assign prod     = {1'b0, acc_in.value, 3'b000} + {3'b000, acc_in.value, 1'b0}
                  + {{(ProdW-4){1'b0}}, digit};

  always_comb begin
    acc_out = acc_in;
    if (acc_in.digits_only) begin
      if (!is_digit) begin
        acc_out.digits_only = 1'b0;
      end else if (prod[ProdW-1:NumW] != 4'd0) begin
        acc_out.value = {NumW{1'b1}};
      end else begin
        acc_out.value = prod[NumW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[design/delimited_frame_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_frame_parser
// Byte-wide parser for '#'-framed text records; tags each byte with its field.
// ----------------------------------------------------------------------------
// Phase update and decimal step share one stage; the result is registered,
// valid in the cycle after accept. 1 byte per cycle while out_ready is high.
// The result register frees for a new byte in the cycle it is taken.
// Reset (rst_n low, synchronous): start phase, accumulator cleared, no result.
module delimited_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_field_code,
  output logic [7:0]  out_content_byte,
  output logic        out_is_content,
  output logic        out_field_end,
  output logic        out_frame_done,
  output logic        out_start_mismatch,
  output logic        out_number_valid,
  output logic [31:0] out_number_value
);
  import dfp_pkg::*;

  logic [PhaseW-1:0] phase_r, phase_nxt;
  acc_t              acc_r, acc_nxt, acc_step;
  logic [NumW-1:0]   size_r, size_nxt;
  logic [NumW-1:0]   count_r, count_nxt, count_inc;
  logic              out_valid_r, out_valid_nxt;
  logic              in_accept;

  logic [PhaseW-1:0] code_nxt;
  logic              content_nxt, fend_nxt, done_nxt, mism_nxt, nvalid_nxt;
  logic [NumW-1:0]   nval_nxt;

  logic [PhaseW-1:0] code_r;
  logic [7:0]        byte_r;
  logic              content_r, fend_r, done_r, mism_r, nvalid_r;
  logic [NumW-1:0]   nval_r;

  dfp_digit_acc u_acc (
    .acc_in   (acc_r),
    .data_byte(in_data_byte),
    .acc_out  (acc_step)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign count_inc = count_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    size_nxt    = size_r;
    count_nxt   = count_r;
    code_nxt    = phase_r;
    content_nxt = 1'b0;
    fend_nxt    = 1'b0;
    done_nxt    = 1'b0;
    mism_nxt    = 1'b0;
    nvalid_nxt  = 1'b0;
    nval_nxt    = '0;
    unique case (phase_r) inside
      PH_PAYLOAD: begin
        content_nxt = 1'b1;
        count_nxt   = count_inc;
        if (count_inc == size_r) begin
          fend_nxt  = 1'b1;
          done_nxt  = 1'b1;
          count_nxt = '0;
          phase_nxt = PH_START;
        end
      end
      PH_TYPE, PH_KEY, PH_MODULE, PH_METHOD, PH_SENDER, PH_MSGTYPE, PH_SIZE: begin
        if (in_data_byte == close_mark(phase_r)) begin
          fend_nxt = 1'b1;
          if (is_numeric(phase_r)) begin
            nvalid_nxt = 1'b1;
            nval_nxt   = acc_r.value;
          end
          if (phase_r == PH_SIZE) begin
            size_nxt  = acc_r.value;
            count_nxt = '0;
            if (acc_r.value == '0) begin
              done_nxt  = 1'b1;
              phase_nxt = PH_START;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
          acc_nxt.value       = '0;
          acc_nxt.digits_only = 1'b1;
        end else begin
          content_nxt = 1'b1;
          if (is_numeric(phase_r)) begin
            acc_nxt = acc_step;
          end
        end
      end
      default: begin
        code_nxt            = PH_START;
        mism_nxt            = (in_data_byte != MARK_HASH);
        acc_nxt.value       = '0;
        acc_nxt.digits_only = 1'b1;
        count_nxt           = '0;
        phase_nxt           = PH_TYPE;
      end
    endcase
  end

  assign out_valid_nxt = in_accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r             <= PH_START;
      acc_r.value         <= '0;
      acc_r.digits_only   <= 1'b1;
      size_r              <= '0;
      count_r             <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        size_r  <= size_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      code_r    <= code_nxt;
      byte_r    <= in_data_byte;
      content_r <= content_nxt;
      fend_r    <= fend_nxt;
      done_r    <= done_nxt;
      mism_r    <= mism_nxt;
      nvalid_r  <= nvalid_nxt;
      nval_r    <= nval_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_field_code     = code_r;
  assign out_content_byte   = byte_r;
  assign out_is_content     = content_r;
  assign out_field_end      = fend_r;
  assign out_frame_done     = done_r;
  assign out_start_mismatch = mism_r;
  assign out_number_valid   = nvalid_r;
  assign out_number_value   = nval_r;

  a_done_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> fend_r)
    else $error("frame done without field end");

  a_number_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && nvalid_r |-> fend_r && !content_r)
    else $error("number reported outside a field close");

  a_mismatch_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mism_r |-> code_r == PH_START)
    else $error("start mismatch outside start phase");

  a_payload_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> count_r < size_r)
    else $error("payload count reached size inside payload");

  a_start_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && done_nxt |=> phase_r == PH_START)
    else $error("phase not back at start after frame done");

endmodule
`default_nettype wire

[tb/tb_delimited_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delimited_frame_parser
// Self-checking bench for the '#'-framed byte parser. Frames are built with
// random content, numeric fields of many shapes (junk, leading zeros, values
// past 32 bits) and short payloads, mixed with noise and cut-off frames. A
// cycle-level predictor tags every accepted byte, and each result is checked
// field by field while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_delimited_frame_parser;
  import dfp_pkg::*;

  localparam int          CycleLimit = 200000;
  localparam int          HoldCycles = 300;
  localparam logic [7:0]  DIGIT_0    = 8'h30;
  localparam logic [7:0]  DIGIT_9    = 8'h39;

  typedef struct packed {
    logic [3:0]  field_code;
    logic [7:0]  content_byte;
    logic        is_content;
    logic        field_end;
    logic        frame_done;
    logic        start_mismatch;
    logic        number_valid;
    logic [31:0] number_value;
  } byte_tag_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_field_code;
  logic [7:0]  out_content_byte;
  logic        out_is_content;
  logic        out_field_end;
  logic        out_frame_done;
  logic        out_start_mismatch;
  logic        out_number_valid;
  logic [31:0] out_number_value;

  delimited_frame_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_field_code     (out_field_code),
    .out_content_byte   (out_content_byte),
    .out_is_content     (out_is_content),
    .out_field_end      (out_field_end),
    .out_frame_done     (out_frame_done),
    .out_start_mismatch (out_start_mismatch),
    .out_number_valid   (out_number_valid),
    .out_number_value   (out_number_value)
  );

  // parser state as predicted
  logic [3:0]  pr_phase  = PH_START;
  logic [31:0] pr_accum  = '0;
  logic        pr_digits = 1'b1;
  logic [31:0] pr_size   = '0;
  logic [31:0] pr_count  = '0;

  byte_tag_t   expected_tags[$];
  logic [7:0]  frame_bytes[$];

  int error_count    = 0;
  int bytes_sent     = 0;
  int tags_checked   = 0;
  int frames_closed  = 0;
  int bad_starts     = 0;
  int numbers_seen   = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int tx_gap_max     = 6;
  bit rx_full_rate   = 1'b0;
  int hold_requests  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] field_delim(input logic [3:0] ph);
    case (ph)
      PH_TYPE:            return MARK_BANG;
      PH_KEY, PH_SENDER:  return MARK_HASH;
      default:            return MARK_BAR;
    endcase
  endfunction

  function automatic byte_tag_t tag_byte(input logic [7:0] b);
    byte_tag_t   t;
    logic [35:0] wide;
    logic        numeric;
    t = '0;
    t.content_byte = b;
    numeric = (pr_phase == PH_TYPE) || (pr_phase == PH_MSGTYPE) || (pr_phase == PH_SIZE);
    if (pr_phase == PH_START || pr_phase > PH_PAYLOAD) begin
      t.field_code = PH_START;
      t.start_mismatch = (b != MARK_HASH);
      pr_accum = '0;
      pr_digits = 1'b1;
      pr_count = '0;
      pr_phase = PH_TYPE;
    end else if (pr_phase == PH_PAYLOAD) begin
      t.field_code = PH_PAYLOAD;
      t.is_content = 1'b1;
      pr_count = pr_count + 1;
      if (pr_count == pr_size) begin
        t.field_end = 1'b1;
        t.frame_done = 1'b1;
        pr_count = '0;
        pr_phase = PH_START;
      end
    end else begin
      t.field_code = pr_phase;
      if (b == field_delim(pr_phase)) begin
        t.field_end = 1'b1;
        if (numeric) begin
          t.number_valid = 1'b1;
          t.number_value = pr_accum;
        end
        if (pr_phase == PH_SIZE) begin
          pr_size = pr_accum;
          pr_count = '0;
          if (pr_accum == 0) begin
            t.frame_done = 1'b1;
            pr_phase = PH_START;
          end else begin
            pr_phase = PH_PAYLOAD;
          end
        end else begin
          pr_phase = pr_phase + 4'd1;
        end
        pr_accum = '0;
        pr_digits = 1'b1;
      end else begin
        t.is_content = 1'b1;
        if (numeric && pr_digits) begin
          if (b >= DIGIT_0 && b <= DIGIT_9) begin
            wide = 36'(pr_accum) * 36'd10 + 36'(b - DIGIT_0);
            pr_accum = (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
          end else begin
            pr_digits = 1'b0;
          end
        end
      end
    end
    return t;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    expected_tags.push_back(tag_byte(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame_bytes(input int count);
    for (int i = 0; i < count; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
  endtask

  // close whatever field is open so the next byte is a start byte
  task automatic resync_to_start();
    while (pr_phase != PH_START)
      send_byte(pr_phase == PH_PAYLOAD ? 8'($urandom) : field_delim(pr_phase));
  endtask

  function automatic logic [7:0] junk_byte(input logic [7:0] mark);
    logic [7:0] c;
    do c = 8'($urandom); while (c == mark || (c >= DIGIT_0 && c <= DIGIT_9));
    return c;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 9);
      1:       return $urandom_range(0, 65535);
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  task automatic add_text(input logic [7:0] mark);
    logic [7:0] c;
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom); while (c == mark);
      frame_bytes.push_back(c);
    end
  endtask

  // wild allows shapes whose parsed value differs from the given value
  task automatic add_number(input logic [7:0] mark, input logic [31:0] value, input bit wild);
    string digits;
    int    style;
    digits = $sformatf("%0d", value);
    style = $urandom_range(0, wild ? 9 : 7);
    if (style == 9) begin
      frame_bytes.push_back(junk_byte(mark));
      add_text(mark);
    end else if (style == 8) begin
      frame_bytes.push_back(DIGIT_0 + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(10, 13)) frame_bytes.push_back(DIGIT_0 + 8'($urandom_range(0, 9)));
    end else begin
      if (style == 5) begin
        frame_bytes.push_back(DIGIT_0);
        frame_bytes.push_back(DIGIT_0);
      end
      if (!(style == 7 && value == 0))
        for (int i = 0; i < digits.len(); i++) frame_bytes.push_back(digits[i]);
      if (style == 6) begin
        frame_bytes.push_back(junk_byte(mark));
        add_text(mark);
      end
    end
  endtask

  task automatic build_frame();
    int n;
    frame_bytes.delete();
    frame_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : MARK_HASH);
    add_number(MARK_BANG, pick_value(), 1'b1);
    frame_bytes.push_back(MARK_BANG);
    add_text(MARK_HASH);
    frame_bytes.push_back(MARK_HASH);
    add_text(MARK_BAR);
    frame_bytes.push_back(MARK_BAR);
    add_text(MARK_BAR);
    frame_bytes.push_back(MARK_BAR);
    add_text(MARK_HASH);
    frame_bytes.push_back(MARK_HASH);
    add_number(MARK_BAR, pick_value(), 1'b1);
    frame_bytes.push_back(MARK_BAR);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 6);
    add_number(MARK_BAR, n, 1'b0);
    frame_bytes.push_back(MARK_BAR);
    repeat (n) frame_bytes.push_back(8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_frames();
    // bad start byte, frozen type value, empty fields, zero size
    send_byte(8'h00);
    send_text("9a!");
    send_byte(8'hFF);
    send_text("#||#|0|");
    // saturated type, msgtype without leading digit, payload of delimiters
    send_text("#42949672960!k#m|f|s#x5|2|#|");
    send_text("#4294967295!#||#007|1|");
    send_byte(8'hFF);
  endtask

  task automatic test_random_frames(input int budget);
    int base_count;
    int kind;
    base_count = bytes_sent;
    while (bytes_sent - base_count < budget) begin
      build_frame();
      kind = $urandom_range(0, 19);
      if (kind < 16) begin
        send_frame_bytes(frame_bytes.size());
      end else if (kind < 18) begin
        send_frame_bytes($urandom_range(1, frame_bytes.size() - 1));
        build_frame();
        send_frame_bytes(frame_bytes.size());
        resync_to_start();
      end else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
        resync_to_start();
      end
    end
  endtask

  task automatic test_output_backpressure();
    tx_gap_max = 0;
    hold_requests++;
    test_random_frames(60);
    tx_gap_max = 6;
  endtask

  task automatic test_full_rate();
    drain_results();
    tx_gap_max = 0;
    rx_full_rate = 1'b1;
    test_random_frames(150);
    rx_full_rate = 1'b0;
    tx_gap_max = 12;
  endtask

  // --------------------------------------------------------------------------
  // receiver: long hold on request, full rate when asked, else a changing stall pattern
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int hold_seen;
    int rx_mode;
    int rx_tick;
    hold_left = 0;
    hold_seen = 0;
    rx_mode = 0;
    rx_tick = 0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_full_rate) begin
        out_ready <= 1'b1;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    byte_tag_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tags.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0d", $time,
                 out_content_byte);
        error_count++;
      end else begin
        want = expected_tags.pop_front();
        check_field("field_code", want.field_code, out_field_code);
        check_field("content_byte", want.content_byte, out_content_byte);
        check_field("is_content", want.is_content, out_is_content);
        check_field("field_end", want.field_end, out_field_end);
        check_field("frame_done", want.frame_done, out_frame_done);
        check_field("start_mismatch", want.start_mismatch, out_start_mismatch);
        check_field("number_valid", want.number_valid, out_number_valid);
        check_field("number_value", want.number_value, out_number_value);
        tags_checked++;
        if (want.frame_done) frames_closed++;
        if (want.start_mismatch) bad_starts++;
        if (want.number_valid) numbers_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, expected_tags.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_random_frames(650);
    test_output_backpressure();
    test_full_rate();
    test_random_frames(400);

    drain_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d bytes: %0d results checked, %0d frames closed,", bytes_sent,
             tags_checked, frames_closed);
    $display("%0d bad start bytes and %0d numeric fields, with stalls on both sides.",
             bad_starts, numbers_seen);
    if (error_count == 0 && expected_tags.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
